@@ src/cstrip_pkg.sv @@
// ----------------------------------------------------------------------------
// cstrip_pkg
// shared types, codes and character constants of the comment stripper
// ----------------------------------------------------------------------------
`default_nettype none

package cstrip_pkg;

    // transaction request codes
    typedef enum logic [1:0] {
        REQ_CHAR  = 2'd0,
        REQ_IDENT = 2'd1,
        REQ_FILE  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_IDENT = 1'b1;

    // configuration register indexes
    localparam logic CFG_BLANK_CHOICE = 1'b0;
    localparam logic CFG_LFSR_SEED    = 1'b1;

    // blank choice modes
    localparam logic [1:0] BLANK_SPACE = 2'd0;
    localparam logic [1:0] BLANK_TAB   = 2'd1;

    localparam logic [1:0]  BLANK_CHOICE_RESET = 2'd2;
    localparam logic [15:0] LFSR_SEED_RESET    = 16'd44257;
    localparam logic [15:0] LFSR_TAPS          = 16'hB400;

    // characters
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // lexer states
    typedef enum logic [3:0] {
        LX_NORMAL  = 4'd0,
        LX_CHAR    = 4'd1,
        LX_STRING  = 4'd2,
        LX_CHAR_BS = 4'd3,
        LX_STR_BS  = 4'd4,
        LX_SLASH   = 4'd5,
        LX_LINE    = 4'd6,
        LX_BLOCK   = 4'd7,
        LX_STAR    = 4'd8
    } lex_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_byte;
        logic [31:0] ident_code;
    } in_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [31:0] out_ident;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  blank_choice;
        logic [15:0] lfsr_seed;
    } cfg_t;

    // results of one transaction, handed to the output queue
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  r0;
        out_item_t  r1;
    } push_t;

    typedef struct packed {
        logic room;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

@@ src/cstrip_lexer.sv @@
// ----------------------------------------------------------------------------
// cstrip_lexer
// lexer state, blank collapsing and result generation for one transaction
// ----------------------------------------------------------------------------
`default_nettype none

module cstrip_lexer
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire cstrip_pkg::in_item_t item,
    input  wire cstrip_pkg::cfg_t     cfg,
    output cstrip_pkg::push_t         push
);

    cstrip_pkg::lex_state_t state_reg, state_next;
    logic                   be_reg, be_next;
    logic [15:0]            lfsr_reg, lfsr_next;

    // blank candidate
    logic        bk_emit;
    logic [7:0]  bk_byte;
    logic [15:0] bk_lfsr;
    logic [15:0] lfsr_step;

    // normal text handling of the current character
    logic                   nc_emit;
    logic [7:0]             nc_byte;
    cstrip_pkg::lex_state_t nc_state;
    logic                   nc_be;
    logic [15:0]            nc_lfsr;

    logic [7:0] c;

    cstrip_pkg::out_item_t  r0, r1;
    logic [1:0]             cnt;

    function automatic cstrip_pkg::out_item_t mk_byte(input logic [7:0] b);
        cstrip_pkg::out_item_t r;
        r.out_kind  = cstrip_pkg::KIND_BYTE;
        r.out_byte  = b;
        r.out_ident = '0;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic cstrip_pkg::out_item_t mk_ident(input logic [31:0] id);
        cstrip_pkg::out_item_t r;
        r.out_kind  = cstrip_pkg::KIND_IDENT;
        r.out_byte  = '0;
        r.out_ident = id;
        r.last      = 1'b0;
        return r;
    endfunction

    assign c = item.char_byte;

    // galois step, then low bit picks space or tab
    always_comb
    begin
        lfsr_step = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? cstrip_pkg::LFSR_TAPS : 16'h0000);
        bk_emit   = !be_reg;
        bk_lfsr   = lfsr_reg;
        case (cfg.blank_choice)
            cstrip_pkg::BLANK_SPACE: bk_byte = cstrip_pkg::CH_SPACE;
            cstrip_pkg::BLANK_TAB:   bk_byte = cstrip_pkg::CH_TAB;
            default:
            begin
                bk_byte = lfsr_step[0] ? cstrip_pkg::CH_TAB : cstrip_pkg::CH_SPACE;
                if (!be_reg)
                begin
                    bk_lfsr = lfsr_step;
                end
            end
        endcase
    end

    always_comb
    begin
        nc_emit  = 1'b1;
        nc_byte  = c;
        nc_state = cstrip_pkg::LX_NORMAL;
        nc_be    = 1'b0;
        nc_lfsr  = lfsr_reg;
        case (c)
            cstrip_pkg::CH_NL:
            begin
                nc_be = 1'b1;
            end
            cstrip_pkg::CH_CR:
            begin
                nc_emit = 1'b0;
                nc_be   = be_reg;
            end
            cstrip_pkg::CH_SPACE, cstrip_pkg::CH_TAB, cstrip_pkg::CH_FF:
            begin
                nc_emit = bk_emit;
                nc_byte = bk_byte;
                nc_be   = 1'b1;
                nc_lfsr = bk_lfsr;
            end
            cstrip_pkg::CH_SLASH:
            begin
                nc_emit  = 1'b0;
                nc_state = cstrip_pkg::LX_SLASH;
            end
            cstrip_pkg::CH_SQUOT: nc_state = cstrip_pkg::LX_CHAR;
            cstrip_pkg::CH_DQUOT: nc_state = cstrip_pkg::LX_STRING;
            default:              nc_state = cstrip_pkg::LX_NORMAL;
        endcase
    end

    // next state and results
    always_comb
    begin
        state_next = state_reg;
        be_next    = be_reg;
        lfsr_next  = lfsr_reg;
        cnt        = 2'd0;
        r0         = mk_byte(c);
        r1         = mk_byte(c);
        case (item.req_type)
            cstrip_pkg::REQ_CHAR:
            begin
                case (state_reg)
                    cstrip_pkg::LX_CHAR:
                    begin
                        cnt = 2'd1;
                        if (c == cstrip_pkg::CH_SQUOT)
                            state_next = cstrip_pkg::LX_NORMAL;
                        else if (c == cstrip_pkg::CH_BSLSH)
                            state_next = cstrip_pkg::LX_CHAR_BS;
                    end
                    cstrip_pkg::LX_STRING:
                    begin
                        cnt = 2'd1;
                        if (c == cstrip_pkg::CH_DQUOT)
                            state_next = cstrip_pkg::LX_NORMAL;
                        else if (c == cstrip_pkg::CH_BSLSH)
                            state_next = cstrip_pkg::LX_STR_BS;
                    end
                    cstrip_pkg::LX_CHAR_BS:
                    begin
                        cnt        = 2'd1;
                        state_next = cstrip_pkg::LX_CHAR;
                    end
                    cstrip_pkg::LX_STR_BS:
                    begin
                        cnt        = 2'd1;
                        state_next = cstrip_pkg::LX_STRING;
                    end
                    cstrip_pkg::LX_SLASH:
                    begin
                        if (c == cstrip_pkg::CH_SLASH || c == cstrip_pkg::CH_STAR)
                        begin
                            // comment opens: it counts as one blank
                            state_next = (c == cstrip_pkg::CH_SLASH) ?
                                         cstrip_pkg::LX_LINE : cstrip_pkg::LX_BLOCK;
                            cnt        = {1'b0, bk_emit};
                            r0         = mk_byte(bk_byte);
                            be_next    = 1'b1;
                            lfsr_next  = bk_lfsr;
                        end
                        else
                        begin
                            // held slash goes first, then normal text
                            r0         = mk_byte(cstrip_pkg::CH_SLASH);
                            r1         = mk_byte(nc_byte);
                            cnt        = nc_emit ? 2'd2 : 2'd1;
                            state_next = nc_state;
                            be_next    = nc_be;
                            lfsr_next  = nc_lfsr;
                        end
                    end
                    cstrip_pkg::LX_LINE:
                    begin
                        if (c == cstrip_pkg::CH_NL)
                        begin
                            state_next = cstrip_pkg::LX_NORMAL;
                            cnt        = 2'd1;
                        end
                    end
                    cstrip_pkg::LX_BLOCK:
                    begin
                        if (c == cstrip_pkg::CH_STAR)
                            state_next = cstrip_pkg::LX_STAR;
                    end
                    cstrip_pkg::LX_STAR:
                    begin
                        if (c == cstrip_pkg::CH_SLASH)
                            state_next = cstrip_pkg::LX_NORMAL;
                        else if (c != cstrip_pkg::CH_STAR)
                            state_next = cstrip_pkg::LX_BLOCK;
                    end
                    default:
                    begin
                        r0         = mk_byte(nc_byte);
                        cnt        = {1'b0, nc_emit};
                        state_next = nc_state;
                        be_next    = nc_be;
                        lfsr_next  = nc_lfsr;
                    end
                endcase
            end
            cstrip_pkg::REQ_IDENT:
            begin
                be_next = 1'b0;
                if (state_reg == cstrip_pkg::LX_SLASH)
                begin
                    r0         = mk_byte(cstrip_pkg::CH_SLASH);
                    r1         = mk_ident(item.ident_code);
                    cnt        = 2'd2;
                    state_next = cstrip_pkg::LX_NORMAL;
                end
                else
                begin
                    r0  = mk_ident(item.ident_code);
                    cnt = 2'd1;
                end
            end
            cstrip_pkg::REQ_FILE:
            begin
                state_next = cstrip_pkg::LX_NORMAL;
                be_next    = 1'b0;
                lfsr_next  = cfg.lfsr_seed;
            end
            default:
            begin
                cnt = 2'd0;
            end
        endcase
        r0.last = (cnt == 2'd1);
        r1.last = 1'b1;
    end

    always_comb
    begin
        push.cnt = advance ? cnt : 2'd0;
        push.r0  = r0;
        push.r1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cstrip_pkg::LX_NORMAL;
            be_reg    <= 1'b0;
            lfsr_reg  <= cstrip_pkg::LFSR_SEED_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            be_reg    <= be_next;
            lfsr_reg  <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

@@ src/cstrip_out_queue.sv @@
// ----------------------------------------------------------------------------
// cstrip_out_queue
// four-entry result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cstrip_out_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cstrip_pkg::push_t     push,
    input  wire logic                  pop,
    output cstrip_pkg::out_item_t      head,
    output cstrip_pkg::q_status_t      status
);

    cstrip_pkg::out_item_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_inc;

    assign wr_ptr_inc   = wr_ptr_reg + 2'd1;
    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 3'd0);
    // room for a two-result transaction, counted before this cycle's pop
    assign status.room  = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/c_comment_strip_space_collapse_unit.sv @@
// ----------------------------------------------------------------------------
// c_comment_strip_space_collapse_unit
// c comment stripper with blank collapsing and identifier pass-through
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while not stalled: a source character, an
// identifier code or a file start. Comments are removed, literals pass with
// their escapes, carriage returns outside literals are dropped and runs of
// blanks become a single space or tab. A '/' is held until the next
// transaction shows whether it opens a comment. Each transaction is registered
// on entry, resolved by the lexer once the output queue has room for two
// results, and its zero, one or two results are written into a four-entry
// output queue; the first result is offered at the output once it has been
// written into the queue. The sustained rate is one transaction per cycle while
// results are drained at one per cycle; the single output port sets the long
// run limit of one result per cycle, so a stream of two-result transactions
// is held back by input stalls. Configuration writes are taken in any cycle
// and must be made only while the block is idle.
`default_nettype none

module c_comment_strip_space_collapse_unit
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire cstrip_pkg::in_item_t  in_data,

    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output cstrip_pkg::out_item_t      out_data,

    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [15:0]           cfg_data
);

    // input register stage
    logic                  in_valid_reg;
    cstrip_pkg::in_item_t  in_data_reg;

    // configuration registers
    cstrip_pkg::cfg_t      cfg_reg;

    cstrip_pkg::push_t     push;
    cstrip_pkg::q_status_t q_status;
    logic                  advance;
    logic                  pop;

    // the held transaction is resolved when the queue can take two results
    assign advance   = in_valid_reg && q_status.room;
    assign in_stall  = in_valid_reg && !q_status.room;
    assign out_valid = !q_status.empty;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // configuration writes; a written seed only takes effect at file start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank_choice <= cstrip_pkg::BLANK_CHOICE_RESET;
            cfg_reg.lfsr_seed    <= cstrip_pkg::LFSR_SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cstrip_pkg::CFG_BLANK_CHOICE: cfg_reg.blank_choice <= cfg_data[1:0];
                cstrip_pkg::CFG_LFSR_SEED:    cfg_reg.lfsr_seed    <= cfg_data;
                default:                      cfg_reg              <= cfg_reg;
            endcase
        end
    end

    cstrip_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .push    (push)
    );

    cstrip_out_queue u_out_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (out_data),
        .status (q_status)
    );

endmodule

`default_nettype wire
